>>> hdl/bsfr_pkg.sv
package bsfr_pkg;

	localparam logic [7:0] FLAG_BYTE   = 8'h7E;
	localparam logic [7:0] ESCAPE_BYTE = 8'h7D;
	localparam logic [7:0] XOR_MASK    = 8'h20;
	localparam logic [7:0] GOOD_SUM    = 8'hFF;

	localparam logic [7:0] MAX_FRAME_RESET = 8'd64;
	localparam logic [4:0] HEADER_RESET    = 5'd4;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 8;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_MAX_FRAME = 2'd0,
		CFG_HEADER    = 2'd1
	} cfg_index_t;

	typedef enum logic [2:0] {
		MODE_HUNT   = 3'b001,
		MODE_DATA   = 3'b010,
		MODE_ESCAPE = 3'b100
	} mode_t;

	typedef enum logic {
		KIND_PAYLOAD = 1'b0,
		KIND_VERDICT = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		STATUS_GOOD      = 2'd0,
		STATUS_CHECKSUM  = 2'd1,
		STATUS_TOO_SHORT = 2'd2,
		STATUS_TOO_LONG  = 2'd3
	} status_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] payload_byte;
		logic [7:0] byte_position;
		status_t    frame_status;
		logic [8:0] frame_length;
	} result_t;

	// 8-bit end-around-carry add
	function automatic logic [7:0] eac_add(input logic [7:0] a, input logic [7:0] b);
		logic [8:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[7:0] + {7'd0, s[8]};
	endfunction

endpackage

>>> hdl/bsfr_if.sv
interface bsfr_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] line_byte;

	modport source (output valid, output line_byte, input ready);
	modport sink   (input valid, input line_byte, output ready);
endinterface

interface bsfr_out_if;
	logic       valid;
	logic       ready;
	logic       result_kind;
	logic [7:0] payload_byte;
	logic [7:0] byte_position;
	logic [1:0] frame_status;
	logic [8:0] frame_length;

	modport source (output valid, output result_kind, output payload_byte,
		output byte_position, output frame_status, output frame_length, input ready);
	modport sink   (input valid, input result_kind, input payload_byte,
		input byte_position, input frame_status, input frame_length, output ready);
endinterface

>>> hdl/bsfr_deframe.sv
module bsfr_deframe (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic [7:0]         step_byte,
	input  logic [7:0]         max_frame_bytes,
	input  logic [4:0]         header_bytes,
	output logic               res_valid,
	output bsfr_pkg::result_t  res
);

	bsfr_pkg::mode_t mode_q, mode_d;
	logic [7:0] sum_q, sum_d;
	logic [8:0] count_q, count_d;

	logic [7:0] data_byte;
	logic [7:0] sum_next;
	logic       fits;
	bsfr_pkg::status_t verdict;

	assign data_byte = (mode_q == bsfr_pkg::MODE_ESCAPE) ?
		(step_byte ^ bsfr_pkg::XOR_MASK) : step_byte;
	assign sum_next  = bsfr_pkg::eac_add(sum_q, data_byte);
	assign fits      = count_q <= {1'b0, max_frame_bytes};

	always_comb begin
		if (sum_q != bsfr_pkg::GOOD_SUM) begin
			verdict = bsfr_pkg::STATUS_CHECKSUM;
		end else if (count_q <= {4'd0, header_bytes}) begin
			verdict = bsfr_pkg::STATUS_TOO_SHORT;
		end else if (count_q > ({1'b0, max_frame_bytes} + 9'd1)) begin
			verdict = bsfr_pkg::STATUS_TOO_LONG;
		end else begin
			verdict = bsfr_pkg::STATUS_GOOD;
		end
	end

	always_comb begin
		mode_d    = mode_q;
		sum_d     = sum_q;
		count_d   = count_q;
		res_valid = 1'b0;
		res       = '{kind: bsfr_pkg::KIND_PAYLOAD, payload_byte: 8'd0,
			byte_position: 8'd0, frame_status: bsfr_pkg::STATUS_GOOD, frame_length: 9'd0};
		if (step) begin
			unique case (mode_q) inside
				bsfr_pkg::MODE_DATA, bsfr_pkg::MODE_ESCAPE: begin
					if (mode_q == bsfr_pkg::MODE_DATA && step_byte == bsfr_pkg::ESCAPE_BYTE) begin
						mode_d = bsfr_pkg::MODE_ESCAPE;
					end else if (mode_q == bsfr_pkg::MODE_DATA &&
							step_byte == bsfr_pkg::FLAG_BYTE) begin
						// close the frame and open the next one
						res_valid         = 1'b1;
						res.kind          = bsfr_pkg::KIND_VERDICT;
						res.frame_status  = verdict;
						res.frame_length  = count_q;
						sum_d             = 8'd0;
						count_d           = 9'd0;
					end else if (fits) begin
						res_valid         = 1'b1;
						res.payload_byte  = data_byte;
						res.byte_position = count_q[7:0];
						sum_d             = sum_next;
						count_d           = count_q + 9'd1;
						mode_d            = bsfr_pkg::MODE_DATA;
					end else begin
						// overflow: report too long and drop back to hunting
						res_valid         = 1'b1;
						res.kind          = bsfr_pkg::KIND_VERDICT;
						res.frame_status  = bsfr_pkg::STATUS_TOO_LONG;
						res.frame_length  = count_q;
						sum_d             = 8'd0;
						count_d           = 9'd0;
						mode_d            = bsfr_pkg::MODE_HUNT;
					end
				end
				default: begin
					mode_d = bsfr_pkg::MODE_HUNT;
					if (step_byte == bsfr_pkg::FLAG_BYTE) begin
						sum_d   = 8'd0;
						count_d = 9'd0;
						mode_d  = bsfr_pkg::MODE_DATA;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= bsfr_pkg::MODE_HUNT;
			sum_q   <= 8'd0;
			count_q <= 9'd0;
		end else begin
			mode_q  <= mode_d;
			sum_q   <= sum_d;
			count_q <= count_d;
		end
	end

endmodule

>>> hdl/byte_stuffed_frame_receiver.sv
// A word accepted from rx_in lands in the input register (byte_s1); its result
// word (if any) is then registered into the output register when stage 1 advances.
// Throughput: one line byte per cycle while the output side takes words.
// Reset (arst_n low): receiver hunts for an opening flag, sum and count clear,
// max_frame_bytes returns to 64 and header_bytes to 4.
module byte_stuffed_frame_receiver (
	input  logic                                  clk,
	input  logic                                  arst_n,
	bsfr_in_if.sink                               rx_in,
	bsfr_out_if.source                            res_out,
	input  logic                                  cfg_we,
	input  logic [bsfr_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [bsfr_pkg::CFG_DATA_W-1:0]       cfg_data
);

	logic [7:0] max_frame_q;
	logic [4:0] header_q;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       advance;

	logic              res_valid;
	bsfr_pkg::result_t res;

	logic              out_valid_q;
	bsfr_pkg::result_t out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_frame_q <= bsfr_pkg::MAX_FRAME_RESET;
			header_q    <= bsfr_pkg::HEADER_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bsfr_pkg::CFG_MAX_FRAME: max_frame_q <= cfg_data;
				bsfr_pkg::CFG_HEADER:    header_q    <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	// stage 1 moves on whenever the result register is free or being drained
	assign advance     = valid_s1 && (!out_valid_q || res_out.ready);
	assign rx_in.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx_in.ready) begin
			valid_s1 <= rx_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_in.ready && rx_in.valid) begin
			byte_s1 <= rx_in.line_byte;
		end
	end

	bsfr_deframe u_deframe (
		.clk             (clk),
		.arst_n          (arst_n),
		.step            (advance),
		.step_byte       (byte_s1),
		.max_frame_bytes (max_frame_q),
		.header_bytes    (header_q),
		.res_valid       (res_valid),
		.res             (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || res_out.ready) begin
			out_valid_q <= advance && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			out_q <= res;
		end
	end

	assign res_out.valid         = out_valid_q;
	assign res_out.result_kind   = out_q.kind;
	assign res_out.payload_byte  = out_q.payload_byte;
	assign res_out.byte_position = out_q.byte_position;
	assign res_out.frame_status  = out_q.frame_status;
	assign res_out.frame_length  = out_q.frame_length;

endmodule
